FILE: rtl/wsd_pkg.sv
package wsd_pkg;

    localparam int ByteWidth  = 8;
    localparam int KindWidth  = 3;
    localparam int CauseWidth = 3;

    // Event kinds reported per input byte
    localparam logic [KindWidth-1:0] EV_HDR   = 3'd0;
    localparam logic [KindWidth-1:0] EV_DATA  = 3'd1;
    localparam logic [KindWidth-1:0] EV_EMPTY = 3'd2;
    localparam logic [KindWidth-1:0] EV_CLOSE = 3'd3;
    localparam logic [KindWidth-1:0] EV_PING  = 3'd4;
    localparam logic [KindWidth-1:0] EV_ERR   = 3'd5;
    localparam logic [KindWidth-1:0] EV_IGN   = 3'd6;

    // Error causes
    localparam logic [CauseWidth-1:0] ERR_NONE    = 3'd0;
    localparam logic [CauseWidth-1:0] ERR_NO_FIN  = 3'd1;
    localparam logic [CauseWidth-1:0] ERR_MASK    = 3'd2;
    localparam logic [CauseWidth-1:0] ERR_PING    = 3'd3;
    localparam logic [CauseWidth-1:0] ERR_OPCODE  = 3'd4;
    localparam logic [CauseWidth-1:0] ERR_LENGTH  = 3'd5;

    // Opcodes
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    // Length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef struct packed {
        logic [KindWidth-1:0]  event_kind;
        logic [ByteWidth-1:0]  payload_byte;
        logic                  frame_end;
        logic [CauseWidth-1:0] error_cause;
    } wsd_result_t;

endpackage

FILE: rtl/wsd_parser.sv
module wsd_parser #(
    parameter int COUNT_WIDTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_accept,
    input  logic [7:0]            in_byte,
    input  logic                  in_new_conn,
    output wsd_pkg::wsd_result_t  result
);
    import wsd_pkg::*;

    localparam int LenBits  = (COUNT_WIDTH < 64) ? COUNT_WIDTH : 63;
    localparam int OvfShift = LenBits - 8;

    typedef enum logic [2:0] {
        PH_HDR1   = 3'd0,
        PH_HDR2   = 3'd1,
        PH_EXT    = 3'd2,
        PH_PAY    = 3'd3,
        PH_CLOSED = 3'd4,
        PH_ERR    = 3'd5
    } phase_t;

    phase_t                 phase_reg, phase_next, phase_eff;
    logic [4:0]             fhb_reg, fhb_next, fhb_eff;
    logic [3:0]             left_reg, left_next, left_eff;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next, rem_eff;

    logic [COUNT_WIDTH-1:0] rem_shifted;
    logic [3:0]             left_dec;
    logic [3:0]             opcode;
    logic [6:0]             len7;
    logic                   len_ovf;

    // A new connection clears all state before this byte is parsed
    always_comb begin
        if (in_new_conn) begin
            phase_eff = PH_HDR1;
            fhb_eff   = '0;
            left_eff  = '0;
            rem_eff   = '0;
        end else begin
            phase_eff = phase_reg;
            fhb_eff   = fhb_reg;
            left_eff  = left_reg;
            rem_eff   = rem_reg;
        end
    end

    assign opcode      = fhb_eff[3:0];
    assign len7        = in_byte[6:0];
    assign len_ovf     = |rem_eff[COUNT_WIDTH-1:OvfShift];
    assign rem_shifted = {rem_eff[COUNT_WIDTH-9:0], in_byte};
    assign left_dec    = (left_eff != 4'd0) ? (left_eff - 4'd1) : 4'd0;

    always_comb begin
        phase_next = phase_eff;
        fhb_next   = fhb_eff;
        left_next  = left_eff;
        rem_next   = rem_eff;

        result.event_kind   = EV_HDR;
        result.payload_byte = '0;
        result.frame_end    = 1'b0;
        result.error_cause  = ERR_NONE;

        unique case (phase_eff)
            PH_HDR1: begin
                fhb_next   = {in_byte[7], in_byte[3:0]};
                phase_next = PH_HDR2;
            end
            PH_HDR2: begin
                if (!fhb_eff[4]) begin
                    phase_next         = PH_ERR;
                    fhb_next           = {2'b00, ERR_NO_FIN};
                    result.event_kind  = EV_ERR;
                    result.error_cause = ERR_NO_FIN;
                end else if (in_byte[7]) begin
                    phase_next         = PH_ERR;
                    fhb_next           = {2'b00, ERR_MASK};
                    result.event_kind  = EV_ERR;
                    result.error_cause = ERR_MASK;
                end else if (opcode == OP_TEXT || opcode == OP_BINARY) begin
                    if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                        left_next  = (len7 == LEN_EXT64) ? 4'd8 : 4'd2;
                        rem_next   = '0;
                        phase_next = PH_EXT;
                    end else if (len7 == 7'd0) begin
                        result.event_kind = EV_EMPTY;
                        result.frame_end  = 1'b1;
                        phase_next        = PH_HDR1;
                    end else begin
                        rem_next   = {{(COUNT_WIDTH-7){1'b0}}, len7};
                        phase_next = PH_PAY;
                    end
                end else if (opcode == OP_CLOSE) begin
                    result.event_kind = EV_CLOSE;
                    phase_next        = PH_CLOSED;
                end else if (opcode == OP_PING) begin
                    if (len7 != 7'd0) begin
                        phase_next         = PH_ERR;
                        fhb_next           = {2'b00, ERR_PING};
                        result.event_kind  = EV_ERR;
                        result.error_cause = ERR_PING;
                    end else begin
                        result.event_kind = EV_PING;
                        result.frame_end  = 1'b1;
                        phase_next        = PH_HDR1;
                    end
                end else begin
                    phase_next         = PH_ERR;
                    fhb_next           = {2'b00, ERR_OPCODE};
                    result.event_kind  = EV_ERR;
                    result.error_cause = ERR_OPCODE;
                end
            end
            PH_EXT: begin
                if (len_ovf) begin
                    phase_next         = PH_ERR;
                    fhb_next           = {2'b00, ERR_LENGTH};
                    result.event_kind  = EV_ERR;
                    result.error_cause = ERR_LENGTH;
                end else begin
                    rem_next  = rem_shifted;
                    left_next = left_dec;
                    if (left_dec == 4'd0) begin
                        if (rem_shifted == '0) begin
                            result.event_kind = EV_EMPTY;
                            result.frame_end  = 1'b1;
                            phase_next        = PH_HDR1;
                        end else begin
                            phase_next = PH_PAY;
                        end
                    end
                end
            end
            PH_PAY: begin
                result.event_kind   = EV_DATA;
                result.payload_byte = in_byte;
                rem_next = (rem_eff != '0) ? (rem_eff - 1'b1) : '0;
                // last byte once the count would reach zero
                if (rem_eff <= {{(COUNT_WIDTH-1){1'b0}}, 1'b1}) begin
                    result.frame_end = 1'b1;
                    phase_next       = PH_HDR1;
                end
            end
            PH_ERR: begin
                result.event_kind  = EV_ERR;
                result.error_cause = fhb_eff[2:0];
            end
            default: begin
                result.event_kind = EV_IGN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR1;
            fhb_reg   <= '0;
            left_reg  <= '0;
            rem_reg   <= '0;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            fhb_reg   <= fhb_next;
            left_reg  <= left_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

FILE: rtl/wsd_out_buf.sv
module wsd_out_buf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wsd_pkg::wsd_result_t  in_result,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wsd_pkg::wsd_result_t  out_result
);
    import wsd_pkg::*;

    logic        main_valid_reg;
    logic        skid_valid_reg;
    wsd_result_t main_reg;
    wsd_result_t skid_reg;
    logic        push;
    logic        pop;

    // ready comes from a register, so the output stall never reaches the input combinationally
    assign in_ready   = !skid_valid_reg;
    assign push       = in_valid && in_ready;
    assign pop        = main_valid_reg && out_ready;
    assign out_valid  = main_valid_reg;
    assign out_result = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_reg       <= in_result;
                main_valid_reg <= 1'b1;
            end else begin
                // hold the item aside while the output stalls
                skid_reg       <= in_result;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: rtl/websocket_frame_deframer.sv
// Websocket frame deframer for the server-to-client direction: one received byte goes in per
// item and exactly one event comes out per item, in order. The block takes a byte every clock
// cycle while s_tready is high; each byte is parsed combinationally against the frame state and
// its event is registered in the output register, or in the skid entry while the output stalls.
// Throughput is one byte per cycle whenever the sink keeps m_tready high. A two-entry output buffer keeps
// s_tready off the m_tready path; s_tready drops only while both entries are full. Set s_tuser
// on the first byte of a new connection to clear all frame state before that byte. Payload
// lengths up to COUNT_WIDTH bits (63 at 64) are accepted; longer extended lengths raise a
// sticky error.
module websocket_frame_deframer #(
    parameter int COUNT_WIDTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    input  logic        s_tuser,   // [0] new_connection
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [10:8] error_cause, [15:11] zero
    output logic [2:0]  m_tuser,   // [2:0] event_kind
    output logic        m_tlast    // frame_end
);
    import wsd_pkg::*;

    wsd_result_t parse_result;
    wsd_result_t out_result;
    logic        in_accept;

    assign in_accept = s_tvalid && s_tready;

    wsd_parser #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_byte     (s_tdata),
        .in_new_conn (s_tuser),
        .result      (parse_result)
    );

    wsd_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_result  (parse_result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {5'b00000, out_result.error_cause, out_result.payload_byte};
    assign m_tuser = out_result.event_kind;
    assign m_tlast = out_result.frame_end;

endmodule

FILE: sim/websocket_frame_deframer_tb.sv
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;
    import wsd_pkg::*;

    localparam int LenBits       = 63;     // usable length bits at COUNT_WIDTH 64
    localparam int RandomItems   = 2000;
    localparam int HoldoffCycles = 300;
    localparam int WatchdogLimit = 3000;
    localparam int MaxPrinted    = 20;

    typedef enum logic [2:0] {
        HDR_FIRST,
        HDR_SECOND,
        EXT_LEN,
        PAYLOAD,
        CLOSED,
        FAILED
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       conn;
    } stream_item_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    stream_item_t stream_items[$];
    wsd_result_t  expected_events[$];

    // frame state of the predictor
    parse_phase_t frame_phase = HDR_FIRST;
    logic [4:0]   hdr_bits = '0;
    logic [3:0]   ext_left = '0;
    logic [63:0]  bytes_left = '0;

    int mismatches = 0;
    int bytes_sent = 0;
    int events_checked = 0;
    int kind_count[8];
    int burst_left = 0;
    int gap_left = 0;
    int ready_mode = 0;
    int ready_cycles = 0;
    int holdoff_left = 0;
    bit holdoff_done = 0;
    int idle_cycles = 0;

    websocket_frame_deframer #(
        .COUNT_WIDTH(64)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic wsd_result_t deframe_byte(input logic [7:0] b, input logic conn_start);
        wsd_result_t r;
        logic [3:0]  op;
        logic [6:0]  len7;
        logic [2:0]  cause;
        if (conn_start) begin
            frame_phase = HDR_FIRST;
            hdr_bits    = '0;
            ext_left    = '0;
            bytes_left  = '0;
        end
        r.event_kind   = EV_HDR;
        r.payload_byte = '0;
        r.frame_end    = 1'b0;
        r.error_cause  = ERR_NONE;
        cause          = ERR_NONE;
        op             = hdr_bits[3:0];
        len7           = b[6:0];
        case (frame_phase)
            HDR_FIRST: begin
                hdr_bits    = {b[7], b[3:0]};
                frame_phase = HDR_SECOND;
            end
            HDR_SECOND: begin
                if (!hdr_bits[4]) begin
                    cause = ERR_NO_FIN;
                end else if (b[7]) begin
                    cause = ERR_MASK;
                end else if (op == OP_TEXT || op == OP_BINARY) begin
                    if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                        ext_left    = (len7 == LEN_EXT64) ? 4'd8 : 4'd2;
                        bytes_left  = '0;
                        frame_phase = EXT_LEN;
                    end else if (len7 == 7'd0) begin
                        r.event_kind = EV_EMPTY;
                        r.frame_end  = 1'b1;
                        frame_phase  = HDR_FIRST;
                    end else begin
                        bytes_left  = 64'(len7);
                        frame_phase = PAYLOAD;
                    end
                end else if (op == OP_CLOSE) begin
                    r.event_kind = EV_CLOSE;
                    frame_phase  = CLOSED;
                end else if (op == OP_PING) begin
                    if (len7 != 7'd0) begin
                        cause = ERR_PING;
                    end else begin
                        r.event_kind = EV_PING;
                        r.frame_end  = 1'b1;
                        frame_phase  = HDR_FIRST;
                    end
                end else begin
                    cause = ERR_OPCODE;
                end
            end
            EXT_LEN: begin
                if ((bytes_left >> (LenBits - 8)) != 0) begin
                    cause = ERR_LENGTH;
                end else begin
                    bytes_left = {bytes_left[55:0], b};
                    if (ext_left > 0) ext_left--;
                    if (ext_left == 0) begin
                        if (bytes_left == 0) begin
                            r.event_kind = EV_EMPTY;
                            r.frame_end  = 1'b1;
                            frame_phase  = HDR_FIRST;
                        end else begin
                            frame_phase = PAYLOAD;
                        end
                    end
                end
            end
            PAYLOAD: begin
                r.event_kind   = EV_DATA;
                r.payload_byte = b;
                if (bytes_left > 0) bytes_left--;
                if (bytes_left == 0) begin
                    r.frame_end = 1'b1;
                    frame_phase = HDR_FIRST;
                end
            end
            FAILED: begin
                // repeat the stored cause on every byte
                cause = hdr_bits[2:0];
            end
            default: begin
                r.event_kind = EV_IGN;
            end
        endcase
        if (cause != ERR_NONE) begin
            frame_phase   = FAILED;
            hdr_bits      = {2'b00, cause};
            r.event_kind  = EV_ERR;
            r.error_cause = cause;
        end
        return r;
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic conn);
        stream_item_t item;
        item.data = b;
        item.conn = conn;
        stream_items.push_back(item);
    endtask

    task automatic put_random_bytes(input int count);
        for (int i = 0; i < count; i++) put_byte(8'($urandom), 1'b0);
    endtask

    task automatic report_mismatch(input string what, input wsd_result_t got,
                                   input wsd_result_t want);
        if (mismatches < MaxPrinted)
            $display("mismatch on event %0d (%s): ", events_checked, what,
                     "got kind %0d byte %02h end %0b cause %0d, ",
                     got.event_kind, got.payload_byte, got.frame_end, got.error_cause,
                     "want kind %0d byte %02h end %0b cause %0d",
                     want.event_kind, want.payload_byte, want.frame_end,
                     want.error_cause);
        mismatches++;
    endtask

    // sender: bursts of items separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                wsd_result_t want;
                want = deframe_byte(s_tdata, s_tuser);
                expected_events.push_back(want);
                kind_count[want.event_kind]++;
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || stream_items.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= stream_items[0].data;
                    s_tuser  <= stream_items[0].conn;
                    stream_items.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // receiver: stall pattern switches between modes, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holdoff_left > 0) begin
            m_tready <= 1'b0;
            holdoff_left--;
        end else if (!holdoff_done && events_checked >= 500) begin
            holdoff_done = 1;
            holdoff_left = HoldoffCycles;
            m_tready <= 1'b0;
        end else begin
            if (ready_cycles == 0) begin
                ready_mode   = $urandom_range(0, 3);
                ready_cycles = $urandom_range(20, 150);
            end else begin
                ready_cycles--;
            end
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= (ready_cycles % 3 != 0);
                default: m_tready <= $urandom_range(0, 1);
            endcase
        end
    end

    // check each accepted event against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            wsd_result_t got;
            wsd_result_t want;
            got.event_kind   = m_tuser;
            got.payload_byte = m_tdata[7:0];
            got.frame_end    = m_tlast;
            got.error_cause  = m_tdata[10:8];
            if (expected_events.size() == 0) begin
                report_mismatch("no event pending", got, '0);
            end else begin
                want = expected_events.pop_front();
                if (got.event_kind !== want.event_kind)
                    report_mismatch("event kind", got, want);
                else if (got.payload_byte !== want.payload_byte)
                    report_mismatch("payload byte", got, want);
                else if (got.frame_end !== want.frame_end)
                    report_mismatch("frame end", got, want);
                else if (got.error_cause !== want.error_cause)
                    report_mismatch("error cause", got, want);
            end
            events_checked++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no item moved for %0d cycles, %0d events still pending",
                     idle_cycles, expected_events.size());
            $display("websocket_frame_deframer_tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [2:0]  rsv;
        logic [3:0]  op;
        logic [63:0] len;
        logic        conn;
        bit          need_conn;
        int          pick;
        int          sel;
        int          total;

        // text frame with one payload byte, empty binary, empty via 16-bit length
        put_byte(8'h81, 1'b0); put_byte(8'h01, 1'b0); put_byte(8'hFF, 1'b0);
        put_byte(8'h82, 1'b0); put_byte(8'h00, 1'b0);
        put_byte(8'h81, 1'b0); put_byte(8'h7E, 1'b0);
        put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
        // ping, then close followed by an ignored byte
        put_byte(8'h89, 1'b0); put_byte(8'h00, 1'b0);
        put_byte(8'h88, 1'b0); put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
        // missing FIN with a sticky repeat, mask set, ping with payload
        put_byte(8'h01, 1'b1); put_byte(8'h00, 1'b0); put_byte(8'h55, 1'b0);
        put_byte(8'h81, 1'b1); put_byte(8'h80, 1'b0);
        put_byte(8'h89, 1'b1); put_byte(8'h7D, 1'b0);
        // bad opcode with RSV bits set
        put_byte(8'hF3, 1'b1); put_byte(8'h00, 1'b0);
        total     = stream_items.size() + RandomItems;
        need_conn = 1;

        while (stream_items.size() < total) begin
            conn      = need_conn || ($urandom_range(0, 15) == 0);
            need_conn = 0;
            rsv       = 3'($urandom);
            op        = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
            pick      = $urandom_range(0, 99);
            if (pick < 62) begin
                put_byte({1'b1, rsv, op}, conn);
                sel = $urandom_range(0, 19);
                if (sel < 12) begin
                    len = $urandom_range(1, (sel < 9) ? 16 : 125);
                    put_byte({1'b0, len[6:0]}, 1'b0);
                end else if (sel < 14) begin
                    len = 0;
                    put_byte(8'h00, 1'b0);
                end else if (sel < 17) begin
                    len = (sel == 16) ? $urandom_range(0, 600) : $urandom_range(0, 40);
                    put_byte({1'b0, LEN_EXT16}, 1'b0);
                    put_byte(len[15:8], 1'b0);
                    put_byte(len[7:0], 1'b0);
                end else begin
                    len = $urandom_range(0, 40);
                    put_byte({1'b0, LEN_EXT64}, 1'b0);
                    for (int i = 7; i >= 0; i--) put_byte(len[8*i +: 8], 1'b0);
                end
                put_random_bytes(int'(len));
            end else if (pick < 68) begin
                put_byte({1'b1, rsv, OP_PING}, conn);
                put_byte(8'h00, 1'b0);
            end else if (pick < 71) begin
                sel = $urandom_range(0, 5);
                put_byte({1'b1, rsv, OP_CLOSE}, conn);
                put_byte({1'b0, 7'(sel)}, 1'b0);
                put_random_bytes(sel + $urandom_range(0, 4));
                need_conn = 1;
            end else if (pick < 76) begin
                // long frame cut short by the next connection
                len = {1'b0, 31'($urandom), 32'($urandom)};
                put_byte({1'b1, rsv, op}, conn);
                if ($urandom_range(0, 1)) begin
                    put_byte({1'b0, LEN_EXT16}, 1'b0);
                    put_byte(len[15:8], 1'b0);
                    put_byte(len[7:0], 1'b0);
                end else begin
                    put_byte({1'b0, LEN_EXT64}, 1'b0);
                    for (int i = 7; i >= 0; i--) put_byte(len[8*i +: 8], 1'b0);
                end
                put_random_bytes($urandom_range(1, 20));
                need_conn = 1;
            end else if (pick < 91) begin
                case ($urandom_range(0, 4))
                    0: begin
                        put_byte({1'b0, rsv, 4'($urandom)}, conn);
                        put_byte(8'($urandom), 1'b0);
                    end
                    1: begin
                        put_byte({1'b1, rsv, 4'($urandom)}, conn);
                        put_byte({1'b1, 7'($urandom)}, 1'b0);
                    end
                    2: begin
                        put_byte({1'b1, rsv, OP_PING}, conn);
                        put_byte({1'b0, 7'($urandom_range(1, 127))}, 1'b0);
                    end
                    3: begin
                        do op = 4'($urandom);
                        while (op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE ||
                               op == OP_PING);
                        put_byte({1'b1, rsv, op}, conn);
                        put_byte({1'b0, 7'($urandom)}, 1'b0);
                    end
                    default: begin
                        // 64-bit length with its top bit set
                        put_byte({1'b1, rsv, op}, conn);
                        put_byte({1'b0, LEN_EXT64}, 1'b0);
                        put_byte({1'b1, 7'($urandom)}, 1'b0);
                        put_random_bytes(7);
                    end
                endcase
                put_random_bytes($urandom_range(0, 6));
                need_conn = 1;
            end else begin
                sel = $urandom_range(1, 10);
                for (int i = 0; i < sel; i++)
                    put_byte(8'($urandom), $urandom_range(0, 3) == 0);
                need_conn = 1;
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        while (stream_items.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d bytes in, %0d events checked, %0d mismatches", bytes_sent,
                 events_checked, mismatches);
        $display("events: %0d header, %0d payload, %0d empty, %0d close, ",
                 kind_count[EV_HDR], kind_count[EV_DATA], kind_count[EV_EMPTY],
                 kind_count[EV_CLOSE],
                 "%0d ping, %0d error, %0d ignored",
                 kind_count[EV_PING], kind_count[EV_ERR], kind_count[EV_IGN]);
        if (mismatches == 0)
            $display("websocket_frame_deframer_tb: PASS");
        else
            $display("websocket_frame_deframer_tb: FAIL");
        $finish;
    end

endmodule
